@@ rtl/linear_interp_resampler_top_macros.svh @@
// Assertion macros shared by the resampler RTL.
`ifndef LINEAR_INTERP_RESAMPLER_TOP_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LIR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/lir_pkg.sv @@
// Package: constants, register codes, helpers and state type of the resampler.
package lir_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int CH_W         = 3;
   localparam int CNT_W        = 4;
   localparam int SAMPLE_W     = 24;
   localparam int RAW_W        = 24;
   localparam int STEP_W       = 27;
   localparam int PHASE_W      = 28;
   localparam int FRAC_W       = 24;
   localparam int DIFF_W       = SAMPLE_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int CSR_IDX_W    = 2;

   localparam logic [PHASE_W-1:0] PHASE_ONE = 28'h100_0000;
   localparam logic [STEP_W-1:0]  STEP_MIN  = 27'd2097152;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = 50'sd8388608;

   // Register reset values
   localparam logic [STEP_W-1:0] STEP_RESET = 27'd16777216;
   localparam logic [CNT_W-1:0]  CH_RESET   = 4'd2;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_CHANNELS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_CHANNELS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_FORMAT = 2'd3;

   localparam logic FMT_S16 = 1'b0;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIFF = 5'b00010,
      S_MUL  = 5'b00100,
      S_RND  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   // Zero counts as one channel, anything above the maximum as the maximum.
   function automatic logic [CNT_W-1:0] clamp_ch(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] r;
      r = c;
      if (c == '0) begin
         r = CNT_W'(1);
      end else if (c > CNT_W'(MAX_CHANNELS)) begin
         r = CNT_W'(MAX_CHANNELS);
      end
      return r;
   endfunction

endpackage

@@ rtl/linear_interp_resampler_top.sv @@
// Linear-interpolation sample-rate converter with one shared multiplier.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_sample_raw[23:0]
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_sample_out, rsp_out_channel,
//          |           |                        | rsp_frame_end, rsp_run_last
//  csr     | in        | csr_valid / csr_ready  | csr_index[1:0], csr_wdata[26:0]
//
// A beat that does not finish an input frame, or that finishes one with no output, is
// stored while the block stays idle. A frame-finishing beat with output yields up to 64
// samples; each passes diff, multiply (on the single multiplier) and round, then waits in
// the output register, held there by any rsp stall. req_ready is low while results run.
// Reset is synchronous; no clearing pass, reset clears the frame stores. csr_ready is always
// high; the user must write the registers only while the block is idle; the block lacks a check.
`include "linear_interp_resampler_top_macros.svh"

module linear_interp_resampler_top
   import lir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [RAW_W-1:0]           req_sample_raw,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   output logic [CH_W-1:0]            rsp_out_channel,
   output logic                       rsp_frame_end,
   output logic                       rsp_run_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [STEP_W-1:0]          csr_wdata
);

   // configuration
   logic [STEP_W-1:0] step_cfg_ff, step_cfg_in;
   logic [CNT_W-1:0]  in_ch_cfg_ff, in_ch_cfg_in;
   logic [CNT_W-1:0]  out_ch_cfg_ff, out_ch_cfg_in;
   logic              fmt_ff, fmt_in;

   // frame history and phase
   logic signed [SAMPLE_W-1:0] prev_ff [MAX_CHANNELS];
   logic signed [SAMPLE_W-1:0] prev_in [MAX_CHANNELS];
   logic signed [SAMPLE_W-1:0] cur_ff  [MAX_CHANNELS];
   logic signed [SAMPLE_W-1:0] cur_in  [MAX_CHANNELS];
   logic [CH_W-1:0]    slot_ff, slot_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               primed_ff, primed_in;

   // sequencer and datapath
   state_type                  state_ff, state_in;
   logic [CH_W-1:0]            ch_ff, ch_in;
   logic signed [DIFF_W-1:0]   diff_ff, diff_in;
   logic signed [SAMPLE_W-1:0] base_ff, base_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [CH_W-1:0]            rsp_chan_ff, rsp_chan_in;
   logic                       rsp_fend_ff, rsp_fend_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [CNT_W-1:0]           in_ch, out_ch;
   logic [STEP_W-1:0]          step_eff;
   logic signed [SAMPLE_W-1:0] decoded;
   logic                       frame_done;
   logic [CH_W-1:0]            ic;
   logic                       last_ch;
   logic [PHASE_W-1:0]         phase_sum, phase_sum_m1;
   logic                       phase_over;
   logic signed [PROD_W-1:0]   rounded;

   assign in_ch    = clamp_ch(in_ch_cfg_ff);
   assign out_ch   = clamp_ch(out_ch_cfg_ff);
   assign step_eff = (step_cfg_ff < STEP_MIN) ? STEP_MIN : step_cfg_ff;

   assign decoded = (fmt_ff == FMT_S16) ? $signed({req_sample_raw[15:0], 8'h00})
                                        : $signed(req_sample_raw[SAMPLE_W-1:0]);

   assign frame_done = ({1'b0, slot_ff} + CNT_W'(1)) >= in_ch;
   assign ic         = ({1'b0, ch_ff} < in_ch) ? ch_ff : '0;
   assign last_ch    = ({1'b0, ch_ff} + CNT_W'(1)) == out_ch;

   assign phase_sum    = phase_ff + PHASE_W'(step_eff);
   assign phase_sum_m1 = phase_ff + PHASE_W'(step_eff) - PHASE_ONE;
   assign phase_over   = phase_sum[PHASE_W-1:FRAC_W] != '0;

   assign rounded = prod_ff + ROUND_BIAS;

   always_comb begin
      state_in      = state_ff;
      step_cfg_in   = step_cfg_ff;
      in_ch_cfg_in  = in_ch_cfg_ff;
      out_ch_cfg_in = out_ch_cfg_ff;
      fmt_in        = fmt_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      slot_in       = slot_ff;
      phase_in      = phase_ff;
      primed_in     = primed_ff;
      ch_in         = ch_ff;
      diff_in       = diff_ff;
      base_in       = base_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_fend_in   = rsp_fend_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cur_in[slot_ff] = decoded;
               if (!frame_done) begin
                  slot_in = slot_ff + CH_W'(1);
               end else begin
                  slot_in = '0;
                  if (!primed_ff) begin
                     primed_in = 1'b1;
                     prev_in   = cur_in;
                  end else if (phase_ff[PHASE_W-1:FRAC_W] == '0) begin
                     ch_in    = '0;
                     state_in = S_DIFF;
                  end else begin
                     // phase lies beyond this frame: drop one frame of phase and slide the history, no output
                     phase_in = phase_ff - PHASE_ONE;
                     prev_in  = cur_in;
                  end
               end
            end
         end
         S_DIFF: begin
            diff_in  = DIFF_W'(cur_ff[ic]) - DIFF_W'(prev_ff[ic]);
            base_in  = prev_ff[ic];
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = diff_ff * $signed({1'b0, phase_ff[FRAC_W-1:0]});
            state_in = S_RND;
         end
         S_RND: begin
            rsp_sample_in = base_ff + rounded[FRAC_W +: SAMPLE_W];
            rsp_chan_in   = ch_ff;
            rsp_fend_in   = last_ch;
            rsp_last_in   = last_ch && phase_over;
            rsp_valid_in  = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (!last_ch) begin
                  ch_in    = ch_ff + CH_W'(1);
                  state_in = S_DIFF;
               end else if (!phase_over) begin
                  phase_in = phase_sum;
                  ch_in    = '0;
                  state_in = S_DIFF;
               end else begin
                  // frame used up: drop one frame of phase and advance the history
                  phase_in = phase_sum_m1;
                  prev_in  = cur_ff;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PHASE_STEP:    step_cfg_in   = csr_wdata;
            CSR_IN_CHANNELS:   in_ch_cfg_in  = csr_wdata[CNT_W-1:0];
            CSR_OUT_CHANNELS:  out_ch_cfg_in = csr_wdata[CNT_W-1:0];
            CSR_SAMPLE_FORMAT: fmt_in        = csr_wdata[0];
            default:           fmt_in        = fmt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_cfg_ff   <= STEP_RESET;
         in_ch_cfg_ff  <= CH_RESET;
         out_ch_cfg_ff <= CH_RESET;
         fmt_ff        <= FMT_S16;
         for (int i = 0; i < MAX_CHANNELS; i++) begin
            prev_ff[i] <= '0;
            cur_ff[i]  <= '0;
         end
         slot_ff       <= '0;
         phase_ff      <= '0;
         primed_ff     <= 1'b0;
         ch_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_cfg_ff   <= step_cfg_in;
         in_ch_cfg_ff  <= in_ch_cfg_in;
         out_ch_cfg_ff <= out_ch_cfg_in;
         fmt_ff        <= fmt_in;
         prev_ff       <= prev_in;
         cur_ff        <= cur_in;
         slot_ff       <= slot_in;
         phase_ff      <= phase_in;
         primed_ff     <= primed_in;
         ch_ff         <= ch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff       <= diff_in;
      base_ff       <= base_in;
      prod_ff       <= prod_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_fend_ff   <= rsp_fend_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_frame_end   = rsp_fend_ff;
   assign rsp_run_last    = rsp_last_ff;

   `LIR_ASSERT_NOW(a_no_req_during_rsp, rsp_valid, !req_ready, "req taken while result pending")
   `LIR_ASSERT_NOW(a_phase_below_one, state_ff != S_IDLE,
                   phase_ff[PHASE_W-1:FRAC_W] == '0, "phase not below one frame while busy")
   `LIR_ASSERT_NOW(a_last_ends_frame, rsp_valid && rsp_run_last, rsp_frame_end,
                   "run end not on a frame end")
   `LIR_ASSERT_NEXT(a_idle_after_last, rsp_valid && rsp_ready && rsp_run_last, req_ready,
                    "not ready after final result beat")

endmodule
